// ===== design/sparse_matrix_vector_multiply_assert.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define SMVM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smvm_pkg.sv =====
`default_nettype none

package smvm_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT    = 1'd0,
    CFG_COLUMN_COUNT = 1'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_valid;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== design/smvm_in_if.sv =====
`default_nettype none

interface smvm_in_if import smvm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, cmd, row_index, col_index, data_value, input ready);
  modport sink (input valid, cmd, row_index, col_index, data_value, output ready);
endinterface

`default_nettype wire

// ===== design/smvm_out_if.sv =====
`default_nettype none

interface smvm_out_if import smvm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         result_row;
  logic signed [DATA_W-1:0] row_sum;
  logic                     last_row;

  modport source (output valid, result_row, row_sum, last_row, input ready);
  modport sink (input valid, result_row, row_sum, last_row, output ready);
endinterface

`default_nettype wire

// ===== design/smvm_cfg_if.sv =====
`default_nettype none

interface smvm_cfg_if import smvm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/smvm_ram.sv =====
`default_nettype none

module smvm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/smvm_mac.sv =====
`default_nettype none

module smvm_mac import smvm_pkg::*; (
  input  wire logic              clk,
  input  wire mac_ctl_t          ctl,
  input  wire logic [DATA_W-1:0] mul_a,
  input  wire logic [DATA_W-1:0] mul_b,
  input  wire logic [DATA_W-1:0] acc_in,
  output logic      [DATA_W-1:0] sum
);

  logic [DATA_W-1:0] prod_r;

  // low word of the product only; the sum wraps
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= DATA_W'(mul_a * mul_b);
    end
  end

  assign sum = (ctl.acc_valid ? acc_in : '0) + prod_r;

endmodule

`default_nettype wire

// ===== design/sparse_matrix_vector_multiply.sv =====
// Sparse matrix times dense vector, coordinate format.
// in_req: requests of cmd LOAD (vector element at col_index), ENTRY (adds
//   data_value * vector[col_index] into the sum of row_index) or FINISH.
//   Out-of-range rows or columns and the unused command are dropped.
// out_rsp: on FINISH, one request per row 0..min(row_count,MAX_ROWS)-1 in
//   order with last_row on the final one; the sums are then cleared.
// cfg_wr: index 0 row_count, index 1 column_count; always ready; both reset to
//   64. Write only while the block is idle; the block does not enforce it.
// Sequencing: LOAD is written while the block stays idle. ENTRY reads both
//   memories, then multiplies (ST_MUL), then adds and writes back (ST_ADD)
//   through the one multiply-add unit. FINISH walks the accumulator memory,
//   reading each row (ST_EMIT_RD), then loading it into the output register
//   (ST_EMIT_LD). in_req.ready is low while an entry or a walk runs.
// A result waits in the output register; a stalled receiver holds the walk
//   but a following LOAD or ENTRY is taken as soon as the walk is done.
// Reset (rst_n low, synchronous) clears all sums through per-row valid bits;
//   vector elements hold nothing defined until loaded.
`default_nettype none

module sparse_matrix_vector_multiply import smvm_pkg::*; #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  smvm_in_if.sink    in_req,
  smvm_out_if.source out_rsp,
  smvm_cfg_if.sink   cfg_wr
);

  `include "sparse_matrix_vector_multiply_assert.svh"

  localparam int unsigned RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned VAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [CNT_W-1:0]  live_rows;
  logic [MAX_ROWS-1:0] acc_vld_r, acc_vld_nxt;
  logic [RAW-1:0]    row_r, row_nxt;
  logic [RAW-1:0]    row_cnt_r, row_cnt_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0]  out_row_r, out_row_nxt;
  logic [DATA_W-1:0] out_sum_r, out_sum_nxt;
  logic              out_last_r, out_last_nxt;

  logic in_acc, col_ok, row_ok, out_load, emit_last;
  cmd_t cmd;

  logic              vec_we, acc_we, acc_re;
  logic [RAW-1:0]    acc_raddr;
  logic [DATA_W-1:0] vec_q, acc_q, mac_sum;
  mac_ctl_t          mac_ctl;

  assign cmd       = cmd_t'(in_req.cmd);
  assign live_rows = (rows_cfg_r > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_cfg_r;
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc    = in_req.valid && in_req.ready;
  assign col_ok    = ({1'b0, in_req.col_index} < cols_cfg_r) &&
                     (32'(in_req.col_index) < MAX_COLS);
  assign row_ok    = {1'b0, in_req.row_index} < live_rows;
  assign emit_last = (CNT_W'(row_cnt_r) + CNT_W'(1)) == live_rows;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CNT_W'(64);
      cols_cfg_r <= CNT_W'(64);
    end else if (cfg_wr.valid) begin
      case (cfg_idx_t'(cfg_wr.index))
        CFG_ROW_COUNT:    rows_cfg_r <= cfg_wr.data;
        CFG_COLUMN_COUNT: cols_cfg_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  smvm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (VAW'(in_req.col_index)),
    .wdata (in_req.data_value),
    .re    (in_acc),
    .raddr (VAW'(in_req.col_index)),
    .rdata (vec_q)
  );

  smvm_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (row_r),
    .wdata (mac_sum),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_q)
  );

  smvm_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .mul_a  (val_r),
    .mul_b  (vec_q),
    .acc_in (acc_q),
    .sum    (mac_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      acc_vld_r <= acc_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    row_cnt_r  <= row_cnt_nxt;
    val_r      <= val_nxt;
    out_row_r  <= out_row_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    acc_vld_nxt  = acc_vld_r;
    row_nxt      = row_r;
    row_cnt_nxt  = row_cnt_r;
    val_nxt      = val_r;
    out_vld_nxt  = out_vld_r && !out_rsp.ready;
    out_row_nxt  = out_row_r;
    out_sum_nxt  = out_sum_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    vec_we       = 1'b0;
    acc_we       = 1'b0;
    acc_re       = 1'b0;
    acc_raddr    = RAW'(in_req.row_index);
    mac_ctl      = '{mul_en: 1'b0, acc_valid: acc_vld_r[row_r]};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          row_nxt = RAW'(in_req.row_index);
          val_nxt = in_req.data_value;
          case (cmd)
            CMD_LOAD: begin
              vec_we = col_ok;
            end
            CMD_ENTRY: begin
              if (col_ok && row_ok) begin
                acc_re    = 1'b1;
                state_nxt = ST_MUL;
              end
            end
            CMD_FINISH: begin
              row_cnt_nxt = '0;
              if (live_rows == '0) begin
                acc_vld_nxt = '0;
              end else begin
                state_nxt = ST_EMIT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = ST_ADD;
      end
      ST_ADD: begin
        acc_we             = 1'b1;
        acc_vld_nxt[row_r] = 1'b1;
        state_nxt          = ST_IDLE;
      end
      ST_EMIT_RD: begin
        acc_re    = 1'b1;
        acc_raddr = row_cnt_r;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_vld_r || out_rsp.ready) begin
          out_load     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_row_nxt  = IDX_W'(row_cnt_r);
          out_sum_nxt  = acc_vld_r[row_cnt_r] ? acc_q : '0;
          out_last_nxt = emit_last;
          if (emit_last) begin
            acc_vld_nxt = '0;
            state_nxt   = ST_IDLE;
          end else begin
            row_cnt_nxt = row_cnt_r + RAW'(1);
            state_nxt   = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.result_row = out_row_r;
  assign out_rsp.row_sum    = out_sum_r;
  assign out_rsp.last_row   = out_last_r;

  `SMVM_ASSERT_NEXT(a_entry_starts, in_acc && cmd == CMD_ENTRY && col_ok && row_ok, state_r == ST_MUL, "entry did not start multiply")
  `SMVM_ASSERT_NEXT(a_mul_then_add, state_r == ST_MUL, state_r == ST_ADD, "multiply not followed by add")
  `SMVM_ASSERT_NOW(a_write_in_range, acc_we, CNT_W'(row_r) < live_rows, "accumulator write out of range")
  `SMVM_ASSERT_NEXT(a_clear_after_last, out_load && emit_last, acc_vld_r == '0, "sums not cleared after last row")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
  import smvm_pkg::*;

  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned RANDOM_ITEMS = 114;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [DATA_W-1:0] sum;
    logic              last;
  } row_result_t;

  typedef struct {
    bit                is_cfg;
    cfg_idx_t          reg_idx;
    logic [CNT_W-1:0]  reg_val;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] val;
    bit                known;
    logic [DATA_W-1:0] known_sum;
  } plan_step_t;

  logic clk;
  logic rst_n;

  smvm_in_if  in_req();
  smvm_out_if out_rsp();
  smvm_cfg_if cfg_wr();

  sparse_matrix_vector_multiply uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  // predictor state
  logic [DATA_W-1:0] vec_mem [MAX_COLS];
  bit                vec_written [MAX_COLS];
  logic [DATA_W-1:0] row_acc [MAX_ROWS];
  int unsigned       rows_cfg;
  int unsigned       cols_cfg;
  row_result_t       row_sums_due[$];

  plan_step_t  plan[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned useful_items;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit update_sums(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] r,
                                     input logic [IDX_W-1:0] k, input logic [DATA_W-1:0] v,
                                     input bit known, input logic [DATA_W-1:0] known_sum);
    int unsigned nr;
    int unsigned nc;
    row_result_t res;
    nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
    nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
    case (c)
      CMD_LOAD: begin
        if (k < nc) begin
          vec_mem[k] = v;
          vec_written[k] = 1'b1;
          return 1'b1;
        end
      end
      CMD_ENTRY: begin
        if (r < nr && k < nc) begin
          row_acc[r] = row_acc[r] + v * vec_mem[k];
          return 1'b1;
        end
      end
      CMD_FINISH: begin
        for (int i = 0; i < nr; i++) begin
          res.row = i[IDX_W-1:0];
          res.sum = (known && i == r) ? known_sum : row_acc[i];
          res.last = (i == nr - 1);
          row_sums_due.push_back(res);
        end
        foreach (row_acc[i]) row_acc[i] = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_written_col(input int unsigned nc);
    int cands[$];
    for (int i = 0; i < nc; i++) begin
      if (vec_written[i]) cands.push_back(i);
    end
    if (cands.size() == 0) return -1;
    return cands[$urandom_range(cands.size() - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    return IDX_W'($urandom_range(63));
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count(input bit zero_ok);
    case ($urandom_range(9))
      0: return 7'd1;
      1: return 7'd64;
      2: return zero_ok ? 7'd0 : 7'd2;
      3: return CNT_W'($urandom_range(127, 65));
      default: return CNT_W'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic plan_step_t step_req(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] k, input logic [DATA_W-1:0] v);
    plan_step_t s;
    s.is_cfg = 1'b0;
    s.reg_idx = CFG_ROW_COUNT;
    s.reg_val = '0;
    s.cmd = c;
    s.row = r;
    s.col = k;
    s.val = v;
    s.known = 1'b0;
    s.known_sum = '0;
    return s;
  endfunction

  // finish whose sum for row r is known up front
  function automatic plan_step_t step_known(input logic [IDX_W-1:0] r,
                                            input logic [DATA_W-1:0] sum);
    plan_step_t s;
    s = step_req(CMD_FINISH, r, '0, '0);
    s.known = 1'b1;
    s.known_sum = sum;
    return s;
  endfunction

  function automatic plan_step_t step_cfg(input cfg_idx_t idx, input logic [CNT_W-1:0] val);
    plan_step_t s;
    s = step_req(CMD_SPARE, '0, '0, '0);
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] r,
                              input logic [IDX_W-1:0] k, input logic [DATA_W-1:0] v,
                              input bit known, input logic [DATA_W-1:0] known_sum);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.cmd <= c;
    in_req.row_index <= r;
    in_req.col_index <= k;
    in_req.data_value <= v;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    if (update_sums(c, r, k, v, known, known_sum)) useful_items++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_req.valid <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= val;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    if (idx == CFG_ROW_COUNT) rows_cfg = val;
    else cols_cfg = val;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic run_sequence(input bit with_hold);
    logic [CNT_W-1:0] rows_set;
    logic [CNT_W-1:0] cols_set;
    int unsigned live_r;
    int unsigned live_c;
    int unsigned n_loads;
    int unsigned n_mix;
    int unsigned pick;
    int col;
    settle();
    rows_set = with_hold ? 7'd64 : pick_count(1'b1);
    cols_set = pick_count(1'b0);
    write_reg(CFG_ROW_COUNT, rows_set);
    write_reg(CFG_COLUMN_COUNT, cols_set);
    live_r = (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
    live_c = (cols_set > MAX_COLS) ? MAX_COLS : cols_set;
    // stall the receiver right as a full walk starts; the sender keeps offering
    if (with_hold) begin
      hold_cycles = HOLD_LEN;
      send_request(CMD_FINISH, rand_index(), rand_index(), rand_word(), 1'b0, '0);
    end
    n_loads = $urandom_range(6, 1);
    repeat (n_loads) begin
      send_request(CMD_LOAD, rand_index(), IDX_W'($urandom_range(live_c - 1)), rand_word(),
                   1'b0, '0);
    end
    n_mix = $urandom_range(16, 4);
    repeat (n_mix) begin
      pick = $urandom_range(99);
      col = pick_written_col(live_c);
      if (pick < 8) begin
        send_request(CMD_SPARE, rand_index(), rand_index(), rand_word(), 1'b0, '0);
      end else if (pick < 16 && live_c < MAX_COLS) begin
        send_request(CMD_ENTRY, rand_index(), IDX_W'($urandom_range(63, live_c)), rand_word(),
                     1'b0, '0);
      end else if (pick < 24 && live_r < MAX_ROWS && col >= 0) begin
        send_request(CMD_ENTRY, IDX_W'($urandom_range(63, live_r)), IDX_W'(col), rand_word(),
                     1'b0, '0);
      end else if (pick < 30 || col < 0) begin
        send_request(CMD_LOAD, rand_index(), IDX_W'($urandom_range(live_c - 1)), rand_word(),
                     1'b0, '0);
      end else if (pick < 35) begin
        send_request(CMD_FINISH, rand_index(), rand_index(), rand_word(), 1'b0, '0);
      end else begin
        send_request(CMD_ENTRY,
                     (live_r != 0) ? IDX_W'($urandom_range(live_r - 1)) : rand_index(),
                     IDX_W'(col), rand_word(), 1'b0, '0);
      end
    end
    send_request(CMD_FINISH, rand_index(), rand_index(), rand_word(), 1'b0, '0);
  endtask

  // receiver: random stalls, plus a long hold-off counted here
  initial begin
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_rsp.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      if (row_sums_due.size() == 0) begin
        $display("%0t: unexpected row result: expected none, got row %0d sum %h last %b",
                 $time, out_rsp.result_row, out_rsp.row_sum, out_rsp.last_row);
        mismatch_count++;
      end else begin
        want = row_sums_due.pop_front();
        if (out_rsp.result_row !== want.row || out_rsp.row_sum !== want.sum ||
            out_rsp.last_row !== want.last) begin
          $display("%0t: row result mismatch: expected row %0d sum %h last %b, got row %0d sum %h last %b",
                   $time, want.row, want.sum, want.last,
                   out_rsp.result_row, out_rsp.row_sum, out_rsp.last_row);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sparse_matrix_vector_multiply test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_req.valid = 1'b0;
    in_req.cmd = '0;
    in_req.row_index = '0;
    in_req.col_index = '0;
    in_req.data_value = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = CFG_ROW_COUNT;
    cfg_wr.data = '0;
    hold_cycles = 0;
    mismatch_count = 0;
    useful_items = 0;
    send_idle_pct = 24;
    recv_idle_pct = 77;
    rows_cfg = 64;
    cols_cfg = 64;
    foreach (row_acc[i]) row_acc[i] = '0;
    foreach (vec_mem[i]) begin
      vec_mem[i] = '0;
      vec_written[i] = 1'b0;
    end

    plan.push_back(step_known(6'd0, 32'h0000_0000));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd0, 32'h0000_0001));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd63, 32'hFFFF_FFFF));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd1, 32'h7FFF_FFFF));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd2, 32'h8000_0000));
    plan.push_back(step_req(CMD_ENTRY, 6'd0, 6'd0, 32'd5));
    plan.push_back(step_req(CMD_ENTRY, 6'd0, 6'd0, 32'd5));
    plan.push_back(step_req(CMD_ENTRY, 6'd63, 6'd63, 32'h8000_0000));
    plan.push_back(step_req(CMD_ENTRY, 6'd1, 6'd1, 32'h7FFF_FFFF));
    plan.push_back(step_req(CMD_ENTRY, 6'd2, 6'd2, 32'h8000_0000));
    plan.push_back(step_req(CMD_ENTRY, 6'd2, 6'd63, 32'd3));
    plan.push_back(step_req(CMD_SPARE, 6'd5, 6'd0, 32'd7));
    plan.push_back(step_known(6'd63, 32'h8000_0000));
    plan.push_back(step_cfg(CFG_ROW_COUNT, 7'd1));
    plan.push_back(step_cfg(CFG_COLUMN_COUNT, 7'd1));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd5, 32'd9));
    plan.push_back(step_req(CMD_ENTRY, 6'd0, 6'd1, 32'd4));
    plan.push_back(step_req(CMD_ENTRY, 6'd1, 6'd0, 32'd4));
    plan.push_back(step_req(CMD_ENTRY, 6'd0, 6'd0, 32'hFFFF_FFFE));
    plan.push_back(step_known(6'd0, 32'hFFFF_FFFE));
    plan.push_back(step_cfg(CFG_ROW_COUNT, 7'd2));
    plan.push_back(step_cfg(CFG_COLUMN_COUNT, 7'd127));
    plan.push_back(step_req(CMD_ENTRY, 6'd1, 6'd63, 32'd1));
    plan.push_back(step_cfg(CFG_ROW_COUNT, 7'd0));
    plan.push_back(step_req(CMD_FINISH, 6'd0, 6'd0, 32'd0));
    plan.push_back(step_cfg(CFG_ROW_COUNT, 7'd2));
    plan.push_back(step_known(6'd1, 32'h0000_0000));
    plan.push_back(step_cfg(CFG_ROW_COUNT, 7'd127));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd63, 32'd2));
    plan.push_back(step_req(CMD_ENTRY, 6'd63, 6'd63, 32'd3));
    plan.push_back(step_known(6'd63, 32'd6));
    plan.push_back(step_cfg(CFG_COLUMN_COUNT, 7'd0));
    plan.push_back(step_req(CMD_LOAD, 6'd0, 6'd0, 32'd5));
    plan.push_back(step_req(CMD_ENTRY, 6'd0, 6'd0, 32'd5));
    plan.push_back(step_known(6'd0, 32'h0000_0000));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].cmd, plan[i].row, plan[i].col, plan[i].val,
                     plan[i].known, plan[i].known_sum);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 24 : 0;
      useful_items = 0;
      run_sequence(phase == 2);
      while (useful_items < RANDOM_ITEMS / 3) run_sequence(1'b0);
    end

    settle();
    if (mismatch_count == 0 && row_sums_due.size() == 0) begin
      $display("sparse_matrix_vector_multiply test passed");
    end else begin
      $display("sparse_matrix_vector_multiply test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
